FILE: src/trle_pkg.sv
// shared types and constants for the tga run-length pixel decoder
// no dependencies
`timescale 1ns / 1ps

package trle_pkg;

    localparam int AddrWidth = 5;

    typedef enum logic [2:0] {
        REG_RLE_MODE   = 3'd0,
        REG_BPP        = 3'd1,
        REG_WIDTH      = 3'd2,
        REG_HEIGHT     = 3'd3,
        REG_FLIP       = 3'd4
    } reg_index_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_REFUSED  = 2'd1,
        STATUS_IDLE     = 2'd2,
        STATUS_COMPLETE = 2'd3
    } status_t;

    typedef struct packed {
        logic        command;
        logic [7:0]  data_byte;
    } in_beat_t;

    typedef struct packed {
        logic        pixel_valid;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [15:0] column;
        logic [15:0] row;
        logic        image_done;
        logic        run_pending;
        logic [1:0]  status;
    } out_beat_t;

    typedef struct packed {
        logic        rle_mode;
        logic [2:0]  bytes_per_pixel;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic        flip_rows;
    } cfg_t;

    localparam logic        CMD_TICK   = 1'b1;
    localparam logic [7:0]  ALPHA_INIT = 8'hff;

endpackage

FILE: src/trle_step.sv
// decoder state and per-beat next-state logic
// depends on trle_pkg
`timescale 1ns / 1ps

module trle_step (
    input  logic                clk,
    input  logic                rst_n,
    input  trle_pkg::cfg_t      cfg,
    input  logic                advance,
    input  trle_pkg::in_beat_t  beat,
    output trle_pkg::out_beat_t result
);
    import trle_pkg::*;

    logic [3:0][7:0] store_reg, store_next;
    logic [1:0]      byte_index_reg, byte_index_next;
    logic [6:0]      run_left_reg, run_left_next;
    logic            run_repeat_reg, run_repeat_next;
    logic            await_header_reg, await_header_next;
    logic            packet_first_reg, packet_first_next;
    logic [15:0]     column_reg, column_next;
    logic [15:0]     row_reg, row_next;
    logic            finished_reg, finished_next;

    logic [2:0]      eff_bpp;
    logic            repeat_pending;
    logic            emit;
    logic [3:0][7:0] filled;
    logic [3:0][7:0] emit_store;
    logic [1:0]      index_inc;
    logic [15:0]     column_inc;
    logic [15:0]     row_inc;

    always_comb
    begin
        if (cfg.bytes_per_pixel == 3'd0)
            eff_bpp = 3'd1;
        else if (cfg.bytes_per_pixel > 3'd4)
            eff_bpp = 3'd4;
        else
            eff_bpp = cfg.bytes_per_pixel;
    end

    assign repeat_pending = run_repeat_reg && (run_left_reg != 7'd0) && !packet_first_reg;
    assign index_inc      = byte_index_reg + 2'd1;
    assign column_inc     = column_reg + 16'd1;
    assign row_inc        = row_reg + 16'd1;

    always_comb
    begin
        filled                 = store_reg;
        filled[byte_index_reg] = beat.data_byte;
    end

    always_comb
    begin
        store_next        = store_reg;
        byte_index_next   = byte_index_reg;
        run_left_next     = run_left_reg;
        run_repeat_next   = run_repeat_reg;
        await_header_next = await_header_reg;
        packet_first_next = packet_first_reg;
        column_next       = column_reg;
        row_next          = row_reg;
        finished_next     = finished_reg;
        emit              = 1'b0;
        emit_store        = store_reg;
        result            = '0;
        result.status     = STATUS_OK;

        if (finished_reg)
        begin
            result.status = STATUS_COMPLETE;
        end
        else if (beat.command == CMD_TICK)
        begin
            if (repeat_pending)
            begin
                run_left_next = run_left_reg - 7'd1;
                if (run_left_next == 7'd0)
                begin
                    run_repeat_next   = 1'b0;
                    await_header_next = 1'b1;
                end
                emit = 1'b1;
            end
            else
            begin
                result.status = STATUS_IDLE;
            end
        end
        else if (repeat_pending)
        begin
            result.status = STATUS_REFUSED;
        end
        else if (cfg.rle_mode && await_header_reg)
        begin
            run_repeat_next   = beat.data_byte[7];
            run_left_next     = beat.data_byte[6:0];
            await_header_next = 1'b0;
            packet_first_next = 1'b1;
        end
        else if (index_inc == 2'd0 || {1'b0, index_inc} >= eff_bpp)
        begin
            // pixel complete: swap red and blue slots
            emit_store      = {filled[3], filled[0], filled[1], filled[2]};
            store_next      = emit_store;
            byte_index_next = 2'd0;
            if (cfg.rle_mode)
            begin
                if (packet_first_reg)
                    packet_first_next = 1'b0;
                else if (run_left_reg != 7'd0)
                    run_left_next = run_left_reg - 7'd1;
                if (run_left_next == 7'd0)
                begin
                    run_repeat_next   = 1'b0;
                    await_header_next = 1'b1;
                end
            end
            emit = 1'b1;
        end
        else
        begin
            store_next      = filled;
            byte_index_next = index_inc;
        end

        if (emit)
        begin
            result.pixel_valid = 1'b1;
            result.red         = emit_store[0];
            result.green       = emit_store[1];
            result.blue        = emit_store[2];
            result.alpha       = emit_store[3];
            result.column      = column_reg;
            result.row         = cfg.flip_rows ? (cfg.image_height - row_reg - 16'd1) : row_reg;
            if (column_inc >= cfg.image_width)
            begin
                column_next = 16'd0;
                row_next    = row_inc;
                if (row_inc >= cfg.image_height)
                begin
                    finished_next     = 1'b1;
                    result.image_done = 1'b1;
                    run_left_next     = 7'd0;
                    run_repeat_next   = 1'b0;
                    packet_first_next = 1'b0;
                    await_header_next = 1'b1;
                end
            end
            else
            begin
                column_next = column_inc;
            end
        end

        result.run_pending = run_repeat_next && (run_left_next != 7'd0) && !packet_first_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_reg        <= {ALPHA_INIT, 8'd0, 8'd0, 8'd0};
            byte_index_reg   <= '0;
            run_left_reg     <= '0;
            run_repeat_reg   <= 1'b0;
            await_header_reg <= 1'b1;
            packet_first_reg <= 1'b0;
            column_reg       <= '0;
            row_reg          <= '0;
            finished_reg     <= 1'b0;
        end
        else if (advance)
        begin
            store_reg        <= store_next;
            byte_index_reg   <= byte_index_next;
            run_left_reg     <= run_left_next;
            run_repeat_reg   <= run_repeat_next;
            await_header_reg <= await_header_next;
            packet_first_reg <= packet_first_next;
            column_reg       <= column_next;
            row_reg          <= row_next;
            finished_reg     <= finished_next;
        end
    end

endmodule

FILE: src/tga_rle_pixel_decoder.sv
// top level of the tga run-length pixel decoder: config registers, input
// register, output register with skid stage; depends on trle_pkg, trle_step
`timescale 1ns / 1ps

// usage
//   in channel: in_valid/in_stall/in_data carry one beat, either a payload
//   byte (command 0) or a tick (command 1) that releases one repeated pixel
//   out channel: out_valid/out_stall/out_data return exactly one result beat
//   per input beat, in order; pixel_valid marks beats that carry a pixel
//   path: an accepted beat waits in the input register, then its result is
//   registered in the output register, or in the skid stage under a stall
//   throughput: one beat per cycle while in_stall is low; the decoder state
//   updates from the input register, so beats may arrive back to back
//   receiver stall: the output register holds its beat and one more result
//   goes to the skid stage; in_stall rises once skid and input are both full
//   configuration: apb writes at byte address 4*i, only while idle
//   reset: decoder waits for a packet header (in rle mode), position at the
//   first column and row, alpha 255, registers at their defaults
module tga_rle_pixel_decoder (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [trle_pkg::AddrWidth-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  trle_pkg::in_beat_t             in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output trle_pkg::out_beat_t            out_data
);
    import trle_pkg::*;

    cfg_t       cfg_reg;
    reg_index_t reg_sel;

    in_beat_t   in_beat_reg;
    logic       in_full_reg;
    out_beat_t  result;
    out_beat_t  out_beat_reg;
    logic       out_full_reg;
    out_beat_t  skid_beat_reg;
    logic       skid_full_reg;

    logic       in_take;
    logic       advance;
    logic       out_take;

    assign pready  = 1'b1;
    assign reg_sel = reg_index_t'(paddr[AddrWidth-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rle_mode        <= 1'b0;
            cfg_reg.bytes_per_pixel <= 3'd4;
            cfg_reg.image_width     <= 16'd1;
            cfg_reg.image_height    <= 16'd1;
            cfg_reg.flip_rows       <= 1'b0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_sel)
                REG_RLE_MODE: cfg_reg.rle_mode        <= pwdata[0];
                REG_BPP:      cfg_reg.bytes_per_pixel <= pwdata[2:0];
                REG_WIDTH:    cfg_reg.image_width     <= pwdata[15:0];
                REG_HEIGHT:   cfg_reg.image_height    <= pwdata[15:0];
                REG_FLIP:     cfg_reg.flip_rows       <= pwdata[0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_RLE_MODE: prdata = {31'd0, cfg_reg.rle_mode};
            REG_BPP:      prdata = {29'd0, cfg_reg.bytes_per_pixel};
            REG_WIDTH:    prdata = {16'd0, cfg_reg.image_width};
            REG_HEIGHT:   prdata = {16'd0, cfg_reg.image_height};
            REG_FLIP:     prdata = {31'd0, cfg_reg.flip_rows};
            default:      prdata = 32'd0;
        endcase
    end

    // handshake
    assign out_take = out_full_reg && !out_stall;
    assign advance  = in_full_reg && !skid_full_reg;
    assign in_stall = in_full_reg && skid_full_reg;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_full_reg <= 1'b0;
        else if (in_take)
            in_full_reg <= 1'b1;
        else if (advance)
            in_full_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            in_beat_reg <= in_data;
    end

    trle_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .advance (advance),
        .beat    (in_beat_reg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_full_reg  <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            if (out_take)
            begin
                if (skid_full_reg)
                begin
                    out_full_reg  <= 1'b1;
                    skid_full_reg <= advance;
                end
                else
                begin
                    out_full_reg <= advance;
                end
            end
            else if (out_full_reg)
            begin
                if (advance)
                    skid_full_reg <= 1'b1;
            end
            else
            begin
                out_full_reg <= advance;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take && skid_full_reg)
        begin
            out_beat_reg <= skid_beat_reg;
            if (advance)
                skid_beat_reg <= result;
        end
        else if (out_full_reg && !out_take)
        begin
            if (advance)
                skid_beat_reg <= result;
        end
        else if (advance)
        begin
            out_beat_reg <= result;
        end
    end

    assign out_valid = out_full_reg;
    assign out_data  = out_beat_reg;

endmodule
